@@ sv/sha256_pkg.sv @@
// package: payload types, round constants and helper functions for the sha-256 hasher
`default_nettype none
package sha256_pkg;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  word_index;
      logic [31:0] digest_word;
      logic        last_word;
   } rsp_payload_type;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef logic [7:0][31:0] hash_state_type;

   localparam hash_state_type INITIAL_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // round constant lookup
   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      unique case (idx)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // compression control from sequencer to round unit
   typedef struct packed {
      logic start;
      logic step;
      logic fold;
   } round_ctrl_type;

endpackage
`default_nettype wire

@@ sv/sha256_byte_stream_hasher.sv @@
// top level: byte buffer, padding sequencer, round unit and digest output
// an absorb writes its byte into the buffer, or, when it completes a block, starts a compression
// (load, 64 rounds on the single shared round unit, fold)
// a finish pads one byte per cycle up to the block end, then runs a compression per block,
// one block, or two when more than 55 bytes are held, then 8 result transactions
// throughput: one item at a time; ready drops while padding, compression or output runs
// reset: synchronous, active high; restores the initial hash, zero length and fill
`default_nettype none
module sha256_byte_stream_hasher
   import sha256_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   input  wire req_payload_type req_payload,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   output      rsp_payload_type rsp_payload
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAD   = 6'b000010,
      ST_LOAD  = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_FOLD  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  round_ff, round_in;
   logic [5:0]  pad_ff, pad_in;
   logic        final_ff, final_in;
   logic        last_blk_ff, last_blk_in;
   logic [2:0]  out_ff, out_in;

   // block buffer memory, one word per entry
   logic [3:0][7:0] mem [16];
   logic        mem_we;
   logic [5:0]  mem_waddr;
   logic [7:0]  mem_wdata;
   logic [31:0] word_rd_ff;

   round_ctrl_type ctrl;
   logic           restart;
   hash_state_type hash_words;
   logic           req_fire;
   logic [3:0]     rd_word_base;
   logic [5:0]     next_round;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign next_round = round_ff + 6'd1;

   // register the next schedule word in the cycle before its round
   assign rd_word_base = (state_ff == ST_LOAD) ? 4'd0 : next_round[3:0];

   // first byte of a word sits in the most significant lane
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr[5:2]][2'd3 - mem_waddr[1:0]] <= mem_wdata;
      end
      word_rd_ff <= mem[rd_word_base];
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      bits_in     = bits_ff;
      round_in    = round_ff;
      pad_in      = pad_ff;
      final_in    = final_ff;
      last_blk_in = last_blk_ff;
      out_in      = out_ff;
      mem_we      = 1'b0;
      mem_waddr   = fill_ff;
      mem_wdata   = req_payload.data_byte;
      ctrl        = '0;
      restart     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_payload.opcode == OP_ABSORB) begin
                  mem_we   = 1'b1;
                  bits_in  = bits_ff + 64'd8;
                  fill_in  = fill_ff + 6'd1;
                  final_in = 1'b0;
                  last_blk_in = 1'b0;
                  if (fill_ff == 6'd63) begin
                     state_in = ST_LOAD;
                  end
               end else begin
                  mem_we    = 1'b1;
                  mem_wdata = PAD_BYTE;
                  final_in  = 1'b1;
                  pad_in    = fill_ff + 6'd1;
                  last_blk_in = (fill_ff < 6'd56);
                  state_in  = (fill_ff == 6'd63) ? ST_LOAD : ST_PAD;
               end
            end
         end
         // one padding byte per cycle up to the block end
         ST_PAD: begin
            mem_we    = 1'b1;
            mem_waddr = pad_ff;
            mem_wdata = 8'h00;
            if (last_blk_ff && pad_ff >= 6'd56) begin
               mem_wdata = bits_ff[8'd63 - {2'b00, pad_ff[2:0], 3'b000} -: 8];
            end
            pad_in = pad_ff + 6'd1;
            if (pad_ff == 6'd63) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctrl.start = 1'b1;
            round_in   = 6'd0;
            state_in   = ST_ROUND;
         end
         ST_ROUND: begin
            ctrl.step = 1'b1;
            round_in  = next_round;
            if (round_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            ctrl.fold = 1'b1;
            fill_in   = 6'd0;
            if (!final_ff) begin
               state_in = ST_IDLE;
            end else if (last_blk_ff) begin
               out_in   = 3'd0;
               state_in = ST_OUT;
            end else begin
               // second final block: zeros then the length
               last_blk_in = 1'b1;
               pad_in      = 6'd0;
               state_in    = ST_PAD;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               out_in = out_ff + 3'd1;
               if (out_ff == 3'd7) begin
                  restart  = 1'b1;
                  fill_in  = 6'd0;
                  bits_in  = 64'd0;
                  final_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= 6'd0;
         bits_ff     <= 64'd0;
         final_ff    <= 1'b0;
         last_blk_ff <= 1'b0;
         out_ff      <= 3'd0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         bits_ff     <= bits_in;
         final_ff    <= final_in;
         last_blk_ff <= last_blk_in;
         out_ff      <= out_in;
      end
      round_ff <= round_in;
      pad_ff   <= pad_in;
   end

   sha256_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .round_idx  (round_ff),
      .block_word (word_rd_ff),
      .restart    (restart),
      .hash_words (hash_words)
   );

   // digest output, read straight from the hash register
   assign rsp_valid               = (state_ff == ST_OUT);
   assign rsp_payload.word_index  = out_ff;
   assign rsp_payload.digest_word = hash_words[3'd7 - out_ff];
   assign rsp_payload.last_word   = (out_ff == 3'd7);

   // a compression always runs 64 rounds before the fold
   a_fold_after_last_round: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FOLD |-> $past(state_ff) == ST_ROUND && $past(round_ff) == 6'd63)
      else $error("fold without completing the rounds");

   // input is never taken while results are pending
   a_no_accept_during_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted during digest output");

   // digest output only after the block that holds the length
   a_output_after_final: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> final_ff && last_blk_ff)
      else $error("digest emitted before the length block");

endmodule
`default_nettype wire

@@ sv/sha256_round.sv @@
// round unit: message schedule window and one compression round per cycle
`default_nettype none
module sha256_round
   import sha256_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire round_ctrl_type ctrl,
   input  wire logic [5:0]     round_idx,
   input  wire logic [31:0]    block_word,
   input  wire logic           restart,
   output      hash_state_type hash_words
);

   hash_state_type hash_ff, hash_in;
   hash_state_type work_ff, work_in;
   logic [15:0][31:0] sched_ff, sched_in;

   logic [31:0] w_cur, s0, s1, w_new;
   logic [31:0] big0, big1, ch, maj, t1, t2;
   logic [31:0] a, b, c, d, e, f, g, h;

   // schedule: first 16 words come from the block, then are expanded
   always_comb begin
      s0 = rotr(sched_ff[14], 7) ^ rotr(sched_ff[14], 18) ^ (sched_ff[14] >> 3);
      s1 = rotr(sched_ff[1], 17) ^ rotr(sched_ff[1], 19) ^ (sched_ff[1] >> 10);
      w_new = s1 + sched_ff[6] + s0 + sched_ff[15];
      w_cur = (round_idx < 6'd16) ? block_word : w_new;
   end

   // one round
   always_comb begin
      {a, b, c, d, e, f, g, h} = work_ff;
      big1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
      ch   = (e & f) ^ (~e & g);
      t1   = h + big1 + ch + round_k(round_idx) + w_cur;
      big0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
      maj  = (a & b) ^ (a & c) ^ (b & c);
      t2   = big0 + maj;
   end

   always_comb begin
      hash_in  = hash_ff;
      work_in  = work_ff;
      sched_in = sched_ff;
      if (ctrl.start) begin
         work_in = hash_ff;
      end else if (ctrl.step) begin
         work_in  = {t1 + t2, a, b, c, d + t1, e, f, g};
         sched_in = {sched_ff[14:0], w_cur};
      end
      if (ctrl.fold) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end
      if (restart) begin
         hash_in = INITIAL_HASH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= INITIAL_HASH;
      end else begin
         hash_ff <= hash_in;
      end
      work_ff  <= work_in;
      sched_ff <= sched_in;
   end

   assign hash_words = hash_ff;

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// testbench for the sha-256 byte stream hasher: predicts digests, checks every word
`default_nettype none
module tb_top;
   import sha256_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   sha256_byte_stream_hasher u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   // clock generation
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // predictor state
   logic [7:0][31:0] model_hash = INITIAL_HASH;
   logic [7:0] model_block [64];
   logic [5:0] model_fill = '0;
   logic [63:0] model_bits = '0;

   req_payload_type pending_items [$];
   rsp_payload_type expected_words [$];
   int mismatch_count = 0;
   int send_idle_pct = 23;
   int recv_idle_pct = 75;
   int hold_off_cycles = 0;
   bit stimulus_done = 1'b0;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one 64-round compression of the model block into the model hash
   task automatic compress_model_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {model_block[4*i], model_block[4*i+1], model_block[4*i+2], model_block[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      {a, b, c, d, e, f, g, h} = model_hash;
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_CONST[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      model_hash[7] += a; model_hash[6] += b; model_hash[5] += c; model_hash[4] += d;
      model_hash[3] += e; model_hash[2] += f; model_hash[1] += g; model_hash[0] += h;
   endtask

   // absorb a byte, or pad, finish and queue the eight digest words
   task automatic predict_digest(input req_payload_type item);
      int pos;
      rsp_payload_type word;
      if (item.opcode == OP_ABSORB) begin
         model_block[model_fill] = item.data_byte;
         model_bits += 64'd8;
         model_fill += 6'd1;
         if (model_fill == 6'd0) compress_model_block();
      end else begin
         pos = model_fill;
         model_block[pos] = PAD_BYTE;
         pos++;
         if (pos > 56) begin
            while (pos < 64) begin model_block[pos] = 8'h00; pos++; end
            compress_model_block();
            pos = 0;
         end
         while (pos < 56) begin model_block[pos] = 8'h00; pos++; end
         for (int i = 0; i < 8; i++) model_block[56+i] = model_bits[63-8*i -: 8];
         compress_model_block();
         for (int i = 0; i < 8; i++) begin
            word.word_index = i[2:0];
            word.digest_word = model_hash[7-i];
            word.last_word = (i == 7);
            expected_words.push_back(word);
         end
         model_hash = INITIAL_HASH;
         model_fill = '0;
         model_bits = '0;
      end
   endtask

   function automatic req_payload_type make_item(input logic op, input logic [7:0] b);
      req_payload_type r;
      r.opcode = op;
      r.data_byte = b;
      return r;
   endfunction

   task automatic queue_message(input int len, input logic [7:0] fixed, input bit rnd);
      for (int i = 0; i < len; i++)
         pending_items.push_back(make_item(OP_ABSORB, rnd ? 8'($urandom) : fixed));
      pending_items.push_back(make_item(OP_FINISH, 8'($urandom)));
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid && req_ready) predict_digest(req_payload);
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= pending_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall and long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_payload_type exp_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transaction: %p", rsp_payload);
         end else begin
            exp_word = expected_words.pop_front();
            if (rsp_payload.word_index !== exp_word.word_index ||
                rsp_payload.digest_word !== exp_word.digest_word ||
                rsp_payload.last_word !== exp_word.last_word) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected idx %0d word %h last %b, got idx %0d word %h last %b",
                           exp_word.word_index, exp_word.digest_word, exp_word.last_word,
                           rsp_payload.word_index, rsp_payload.digest_word,
                           rsp_payload.last_word);
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int count;
      int len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // directed: empty message, extreme bytes, a short message, 55/56 byte fill boundary, a full block
      pending_items.push_back(make_item(OP_FINISH, 8'hff));
      queue_message(1, 8'h00, 0);
      queue_message(1, 8'hff, 0);
      queue_message(3, 8'h00, 1);
      queue_message(55, 8'h00, 1);
      queue_message(56, 8'h00, 1);
      queue_message(64, 8'h00, 1);
      wait_drained();
      // random messages under phase one idling
      count = 0;
      while (count < 80) begin
         len = ($urandom_range(3) == 0) ? $urandom_range(130) : $urandom_range(12);
         queue_message(len, 8'h00, 1);
         count += len + 1;
      end
      // long receiver hold-off while the sender keeps offering
      hold_off_cycles <= 400;
      wait_drained();
      send_idle_pct = 75;
      recv_idle_pct = 23;
      count = 0;
      while (count < 80) begin
         len = $urandom_range(70);
         queue_message(len, 8'h00, 1);
         count += len + 1;
      end
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      count = 0;
      while (count < 80) begin
         len = $urandom_range(70);
         if ($urandom_range(9) == 0) begin
            pending_items.push_back(make_item(OP_ABSORB, 8'($urandom)));
            count += 1;
         end else begin
            queue_message(len, 8'h00, 1);
            count += len + 1;
         end
      end
      wait_drained();
      while (expected_words.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // timeout
   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire
